[hdl/gcba_pkg.sv]
package gcba_pkg;

	localparam int DIM_W = 13;
	localparam int POS_W = 12;
	localparam int GRID_W = 5;
	localparam int PIX_W = 8;
	localparam int SUM_W = 32;
	localparam int CNT_W = 2 * DIM_W;
	localparam int IDX_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W = 4;

	localparam int MAX_GRID_COLS_N = 16;
	localparam int MAX_GRID_ROWS_N = 16;

	localparam logic [DIM_W-1:0] MAX_IMAGE_WIDTH = 13'd4096;
	localparam logic [DIM_W-1:0] MAX_IMAGE_HEIGHT = 13'd4096;
	localparam logic [GRID_W-1:0] MAX_GRID_COLS = 5'd16;
	localparam logic [GRID_W-1:0] MAX_GRID_ROWS = 5'd16;

	// one quotient bit per rebuild step, one mean bit per divide step
	localparam int POS_STEPS = POS_W;
	localparam int DIV_STEPS = PIX_W;

	localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH = 13'd640;
	localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [GRID_W-1:0] RST_GRID_COLS = 5'd3;
	localparam logic [GRID_W-1:0] RST_GRID_ROWS = 5'd3;
	localparam logic [DIM_W-1:0] RST_CELL_WIDTH = 13'd213;
	localparam logic [DIM_W-1:0] RST_CELL_HEIGHT = 13'd160;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_GRID_COLS    = 3'd2,
		REG_GRID_ROWS    = 3'd3,
		REG_CELL_WIDTH   = 3'd4,
		REG_CELL_HEIGHT  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic pix_accept;
		logic rb_start;
		logic rb_step;
		logic rb_last;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic cell_done;
	} sts_t;

endpackage

[hdl/gcba_ctrl.sv]
module gcba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  logic            wr_en,
	input  gcba_pkg::sts_t  sts,
	output gcba_pkg::cmd_t  cmd
);
	import gcba_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REBUILD,
		ST_DIVIDE,
		ST_HOLD
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic                dirty_q;
	logic                out_valid_q;

	assign in_stall = !(state_q == ST_IDLE && !dirty_q);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.pix_accept = in_valid && !in_stall;
		cmd.rb_start = (state_q == ST_IDLE) && dirty_q;
		cmd.rb_step = (state_q == ST_REBUILD);
		cmd.rb_last = (state_q == ST_REBUILD) && (step_q == STEP_W'(POS_STEPS - 1));
		cmd.div_step = (state_q == ST_DIVIDE);
		cmd.out_load = (state_q == ST_HOLD) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			dirty_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// rebuild cell offsets after any register write
			if (wr_en)
				dirty_q <= 1'b1;
			else if (cmd.rb_start)
				dirty_q <= 1'b0;

			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (dirty_q)
						state_q <= ST_REBUILD;
					else if (cmd.pix_accept && sts.cell_done)
						state_q <= ST_DIVIDE;
				end
				ST_REBUILD: begin
					if (cmd.rb_last)
						state_q <= ST_IDLE;
					else
						step_q <= step_q + STEP_W'(1);
				end
				ST_DIVIDE: begin
					if (step_q == STEP_W'(DIV_STEPS - 1))
						state_q <= ST_HOLD;
					else
						step_q <= step_q + STEP_W'(1);
				end
				ST_HOLD: begin
					if (cmd.out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result loaded over a waiting item");

	a_done_divides: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_accept && sts.cell_done |=> state_q == ST_DIVIDE)
		else $error("finished cell did not start the divide");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> step_q < STEP_W'(DIV_STEPS))
		else $error("divide step count overrun");

	a_write_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> in_stall)
		else $error("item accepted before offset rebuild");
`endif

endmodule

[hdl/gcba_dp.sv]
module gcba_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gcba_pkg::cmd_t                    cmd,
	output gcba_pkg::sts_t                    sts,
	input  logic [7:0]                        blue,
	input  logic [7:0]                        green,
	input  logic [7:0]                        red,
	input  logic                              frame_start,
	input  logic                              wr_en,
	input  logic [gcba_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [gcba_pkg::DIM_W-1:0]        wr_data,
	output logic [7:0]                        cell_index,
	output logic [7:0]                        mean_value,
	output logic                              last_cell
);
	import gcba_pkg::*;

	// configuration
	logic [DIM_W-1:0]  img_w_q, img_h_q, cell_w_q, cell_h_q;
	logic [GRID_W-1:0] grid_c_q, grid_r_q;
	logic [DIM_W-1:0]  iw, ih, cw, ch;
	logic [GRID_W-1:0] gc, gr;

	// position and in-cell offsets
	logic [POS_W-1:0]  x_q, y_q, xo_q, yo_q;
	logic [GRID_W-1:0] cx_q, cy_q;
	logic [POS_W-1:0]  x_e, y_e, xo_e, yo_e;
	logic [GRID_W-1:0] cx_e, cy_e;

	logic [SUM_W-1:0]  sums_q [MAX_GRID_COLS_N];
	logic [CNT_W-1:0]  cnt_q;

	// offset rebuild dividers
	logic [DIM_W-1:0]  xr_q, yr_q;
	logic [POS_W-1:0]  xn_q, yn_q, xd_q, yd_q;
	logic [DIM_W:0]    xs, ys;
	logic              xge, yge;
	logic [DIM_W-1:0]  xr_n, yr_n;
	logic [POS_W-1:0]  xd_n, yd_n;

	// mean divider
	logic [SUM_W-1:0]  mrem_q;
	logic [SUM_W:0]    mdiv_q;
	logic [PIX_W-1:0]  mq_q;
	logic              msat_q;
	logic              mge;

	logic [IDX_W-1:0]  idx_q;
	logic              last_q;

	logic              clear, in_grid, hit, row_end, frame_end;
	logic [PIX_W-1:0]  v;
	logic [SUM_W-1:0]  old_sum, new_sum;
	logic [IDX_W:0]    idx_sum;
	logic [DIM_W-1:0]  x_inc, y_inc;

	function automatic logic [GRID_W-1:0] sat_q(input logic [POS_W-1:0] q);
		sat_q = (|q[POS_W-1:GRID_W]) ? '1 : q[GRID_W-1:0];
	endfunction

	always_comb begin
		iw = (img_w_q == '0) ? DIM_W'(1) : (img_w_q > MAX_IMAGE_WIDTH) ? MAX_IMAGE_WIDTH : img_w_q;
		ih = (img_h_q == '0) ? DIM_W'(1) :
			(img_h_q > MAX_IMAGE_HEIGHT) ? MAX_IMAGE_HEIGHT : img_h_q;
		gc = (grid_c_q == '0) ? GRID_W'(1) : (grid_c_q > MAX_GRID_COLS) ? MAX_GRID_COLS : grid_c_q;
		gr = (grid_r_q == '0) ? GRID_W'(1) : (grid_r_q > MAX_GRID_ROWS) ? MAX_GRID_ROWS : grid_r_q;
		cw = (cell_w_q == '0) ? DIM_W'(1) : cell_w_q;
		ch = (cell_h_q == '0) ? DIM_W'(1) : cell_h_q;
	end

	always_comb begin
		x_e = frame_start ? '0 : x_q;
		y_e = frame_start ? '0 : y_q;
		xo_e = frame_start ? '0 : xo_q;
		yo_e = frame_start ? '0 : yo_q;
		cx_e = frame_start ? '0 : cx_q;
		cy_e = frame_start ? '0 : cy_q;
		clear = frame_start || (x_e == '0 && yo_e == '0);

		v = blue;
		if (green > v)
			v = green;
		if (red > v)
			v = red;

		in_grid = (cx_e < gc) && (cy_e < gr);
		hit = in_grid && ({1'b0, xo_e} == cw - DIM_W'(1)) && ({1'b0, yo_e} == ch - DIM_W'(1));
		old_sum = clear ? '0 : sums_q[cx_e[3:0]];
		new_sum = old_sum + SUM_W'(v);
		idx_sum = (IDX_W + 1)'({5'b0, cx_e[3:0]} * {4'b0, gr}) + (IDX_W + 1)'(cy_e[3:0]);

		x_inc = {1'b0, x_e} + DIM_W'(1);
		y_inc = {1'b0, y_e} + DIM_W'(1);
		row_end = (x_inc >= iw);
		frame_end = (y_inc >= ih);
	end

	assign sts.cell_done = hit;

	// one restoring-division step per cycle for x / cw and y / ch
	always_comb begin
		xs = {xr_q, xn_q[POS_W-1]};
		ys = {yr_q, yn_q[POS_W-1]};
		xge = (xs >= {1'b0, cw});
		yge = (ys >= {1'b0, ch});
		xr_n = xge ? DIM_W'(xs - {1'b0, cw}) : xs[DIM_W-1:0];
		yr_n = yge ? DIM_W'(ys - {1'b0, ch}) : ys[DIM_W-1:0];
		xd_n = {xd_q[POS_W-2:0], xge};
		yd_n = {yd_q[POS_W-2:0], yge};
		mge = ({1'b0, mrem_q} >= mdiv_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= RST_IMAGE_WIDTH;
			img_h_q <= RST_IMAGE_HEIGHT;
			grid_c_q <= RST_GRID_COLS;
			grid_r_q <= RST_GRID_ROWS;
			cell_w_q <= RST_CELL_WIDTH;
			cell_h_q <= RST_CELL_HEIGHT;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_IMAGE_WIDTH:  img_w_q <= wr_data;
				REG_IMAGE_HEIGHT: img_h_q <= wr_data;
				REG_GRID_COLS:    grid_c_q <= wr_data[GRID_W-1:0];
				REG_GRID_ROWS:    grid_r_q <= wr_data[GRID_W-1:0];
				REG_CELL_WIDTH:   cell_w_q <= wr_data;
				REG_CELL_HEIGHT:  cell_h_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			xo_q <= '0;
			yo_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd.pix_accept) begin
			if (row_end) begin
				x_q <= '0;
				xo_q <= '0;
				cx_q <= '0;
				if (frame_end) begin
					y_q <= '0;
					yo_q <= '0;
					cy_q <= '0;
				end else begin
					y_q <= y_inc[POS_W-1:0];
					if ({1'b0, yo_e} == ch - DIM_W'(1)) begin
						yo_q <= '0;
						cy_q <= (cy_e == '1) ? cy_e : cy_e + GRID_W'(1);
					end else begin
						yo_q <= yo_e + POS_W'(1);
						cy_q <= cy_e;
					end
				end
			end else begin
				x_q <= x_inc[POS_W-1:0];
				y_q <= y_e;
				yo_q <= yo_e;
				cy_q <= cy_e;
				if ({1'b0, xo_e} == cw - DIM_W'(1)) begin
					xo_q <= '0;
					cx_q <= (cx_e == '1) ? cx_e : cx_e + GRID_W'(1);
				end else begin
					xo_q <= xo_e + POS_W'(1);
					cx_q <= cx_e;
				end
			end
		end else if (cmd.rb_last) begin
			xo_q <= xr_n[POS_W-1:0];
			yo_q <= yr_n[POS_W-1:0];
			cx_q <= sat_q(xd_n);
			cy_q <= sat_q(yd_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_GRID_COLS_N; i++)
				sums_q[i] <= '0;
		end else if (cmd.pix_accept) begin
			// the pixel's own column takes the new sum if it lies in the grid, the rest clear on a cell row start
			for (int i = 0; i < MAX_GRID_COLS_N; i++) begin
				if (in_grid && cx_e[3:0] == 4'(i))
					sums_q[i] <= new_sum;
				else if (clear)
					sums_q[i] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rb_start) begin
			cnt_q <= {13'b0, cw} * {13'b0, ch};
			xr_q <= '0;
			yr_q <= '0;
			xn_q <= x_q;
			yn_q <= y_q;
			xd_q <= '0;
			yd_q <= '0;
		end else if (cmd.rb_step) begin
			xr_q <= xr_n;
			yr_q <= yr_n;
			xn_q <= {xn_q[POS_W-2:0], 1'b0};
			yn_q <= {yn_q[POS_W-2:0], 1'b0};
			xd_q <= xd_n;
			yd_q <= yd_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_accept && hit) begin
			mrem_q <= new_sum;
			mdiv_q <= {cnt_q, 7'b0};
			mq_q <= '0;
			msat_q <= ({2'b0, new_sum} >= {cnt_q, 8'b0});
			idx_q <= idx_sum[IDX_W-1:0];
			last_q <= (cx_e == gc - GRID_W'(1)) && (cy_e == gr - GRID_W'(1));
		end else if (cmd.div_step) begin
			if (mge)
				mrem_q <= mrem_q - mdiv_q[SUM_W-1:0];
			mq_q <= {mq_q[PIX_W-2:0], mge};
			mdiv_q <= {1'b0, mdiv_q[SUM_W:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cell_index <= idx_q;
			mean_value <= msat_q ? '1 : mq_q;
			last_cell <= last_q;
		end
	end

endmodule

[hdl/grid_cell_brightness_average_top.sv]
// Grid cell mean brightness.
// Input channel: one pixel item (blue, green, red, frame_start) per accepted
// in_valid/in_stall handshake, in raster order. frame_start restarts at (0,0).
// Each pixel's brightness is max(blue, green, red); it is summed into its grid
// cell. When a cell's bottom-right pixel is taken, one item (cell_index,
// mean_value, last_cell) goes out on the out_valid/out_stall channel.
// Throughput: one pixel per cycle while in_stall is low. A pixel that finishes a cell
// is followed, with the input stalled, by a bit-per-cycle divider for the 8-bit mean
// and the load of the output register; the result shows on out_valid the cycle after.
// Pixels keep flowing while a result waits in the output register; a second
// finished cell waits until that register is taken, stalling the input.
// Register writes (wr_en, wr_index, wr_data) take effect at once; after each
// write, and after reset, the input stalls while the in-cell offsets are rebuilt
// from the pixel position with a 12-step divider.
// Reset (arst_n low) restores the default geometry, clears position and sums.
module grid_cell_brightness_average_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        blue,
	input  logic [7:0]                        green,
	input  logic [7:0]                        red,
	input  logic                              frame_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        cell_index,
	output logic [7:0]                        mean_value,
	output logic                              last_cell,
	input  logic                              wr_en,
	input  logic [gcba_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [gcba_pkg::DIM_W-1:0]        wr_data
);
	import gcba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gcba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.wr_en     (wr_en),
		.sts       (sts),
		.cmd       (cmd)
	);

	gcba_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.frame_start (frame_start),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.cell_index  (cell_index),
		.mean_value  (mean_value),
		.last_cell   (last_cell)
	);

endmodule
